/* design/rle_pkg.sv */
// Shared types, constants and color arithmetic for the RGB LED effect renderer.
// No dependencies; every other design file imports this package.
package rle_pkg;

   localparam int SINE_STEPS = 256;
   localparam int DIV_W = 32;
   localparam int DIVS_W = 16;

   localparam logic [2:0] MODE_STATIC   = 3'd0;
   localparam logic [2:0] MODE_BREATH   = 3'd1;
   localparam logic [2:0] MODE_FLOW     = 3'd2;
   localparam logic [2:0] MODE_FLOW_REV = 3'd3;
   localparam logic [2:0] MODE_BLINK    = 3'd4;
   localparam logic [2:0] MODE_RAINBOW  = 3'd5;

   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_PERIOD   = 3'd1;
   localparam logic [2:0] REG_DURATION = 3'd2;
   localparam logic [2:0] REG_EFF_BRI  = 3'd3;
   localparam logic [2:0] REG_BASE     = 3'd4;
   localparam logic [2:0] REG_START    = 3'd5;
   localparam logic [2:0] REG_COUNT    = 3'd6;
   localparam logic [2:0] REG_GLB_BRI  = 3'd7;

   typedef struct packed {
      logic [2:0]  effect_mode;
      logic [15:0] cycle_len;
      logic [15:0] life_len;
      logic [7:0]  effect_brightness;
      logic [23:0] base_color;
      logic [5:0]  range_start;
      logic [6:0]  range_count;
      logic [7:0]  master_level;
   } cfg_type;

   typedef struct packed {
      logic [9:0] tick_ms;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [5:0]  pixel_num;
      logic [23:0] led_color;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_UPDATE, S_MOD_WAIT, S_FDIV_GO, S_FDIV_WAIT, S_RDIV_GO, S_RDIV_WAIT,
      S_PREP, S_SOLID1, S_SOLID2, S_LED_A, S_LED_B, S_LED_C
   } state_type;

   typedef enum logic [1:0] {DIV_MOD, DIV_FRAME, DIV_RANGE} div_sel_type;

   typedef struct packed {
      logic        load_tick;
      logic        update;
      logic        div_start;
      div_sel_type div_sel;
      logic        phase_load;
      logic        q_load;
      logic        r_load;
      logic        prep;
      logic        solid1;
      logic        solid2;
      logic        led_a;
      logic        led_b;
      logic        led_c;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic will_mod;
      logic is_rainbow;
      logic out_free;
      logic led_last;
   } sts_type;

   function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [7:0] b);
      logic [16:0] x;
      logic [16:0] y;
      x = 17'(ch * b);
      y = x + (x >> 8) + 17'd1;
      return y[15:8];
   endfunction

   function automatic logic [23:0] scale_color(input logic [23:0] c, input logic [7:0] b);
      return {scale_ch(c[23:16], b), scale_ch(c[15:8], b), scale_ch(c[7:0], b)};
   endfunction

   function automatic logic [16:0] quarter_sine(input logic [6:0] j);
      logic [16:0] v;
      case (j)
         7'd0: v = 17'd0;         7'd1: v = 17'd1608;      7'd2: v = 17'd3216;
         7'd3: v = 17'd4821;      7'd4: v = 17'd6424;      7'd5: v = 17'd8022;
         7'd6: v = 17'd9616;      7'd7: v = 17'd11204;     7'd8: v = 17'd12785;
         7'd9: v = 17'd14359;     7'd10: v = 17'd15924;    7'd11: v = 17'd17479;
         7'd12: v = 17'd19024;    7'd13: v = 17'd20557;    7'd14: v = 17'd22078;
         7'd15: v = 17'd23586;    7'd16: v = 17'd25080;    7'd17: v = 17'd26558;
         7'd18: v = 17'd28020;    7'd19: v = 17'd29466;    7'd20: v = 17'd30893;
         7'd21: v = 17'd32303;    7'd22: v = 17'd33692;    7'd23: v = 17'd35062;
         7'd24: v = 17'd36410;    7'd25: v = 17'd37736;    7'd26: v = 17'd39040;
         7'd27: v = 17'd40320;    7'd28: v = 17'd41576;    7'd29: v = 17'd42806;
         7'd30: v = 17'd44011;    7'd31: v = 17'd45190;    7'd32: v = 17'd46341;
         7'd33: v = 17'd47464;    7'd34: v = 17'd48559;    7'd35: v = 17'd49624;
         7'd36: v = 17'd50660;    7'd37: v = 17'd51665;    7'd38: v = 17'd52639;
         7'd39: v = 17'd53581;    7'd40: v = 17'd54491;    7'd41: v = 17'd55368;
         7'd42: v = 17'd56212;    7'd43: v = 17'd57022;    7'd44: v = 17'd57797;
         7'd45: v = 17'd58538;    7'd46: v = 17'd59243;    7'd47: v = 17'd59913;
         7'd48: v = 17'd60547;    7'd49: v = 17'd61144;    7'd50: v = 17'd61705;
         7'd51: v = 17'd62228;    7'd52: v = 17'd62714;    7'd53: v = 17'd63162;
         7'd54: v = 17'd63572;    7'd55: v = 17'd63943;    7'd56: v = 17'd64277;
         7'd57: v = 17'd64571;    7'd58: v = 17'd64827;    7'd59: v = 17'd65043;
         7'd60: v = 17'd65220;    7'd61: v = 17'd65358;    7'd62: v = 17'd65457;
         7'd63: v = 17'd65516;    7'd64: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] breath_level(input logic [7:0] k);
      logic [16:0] mag;
      logic [17:0] num;
      logic [25:0] prod;
      mag = k[6] ? quarter_sine(7'd64 - {1'b0, k[5:0]}) : quarter_sine({1'b0, k[5:0]});
      num = k[7] ? (18'd65536 - {1'b0, mag}) : (18'd65536 + {1'b0, mag});
      prod = 26'(num * 8'd255);
      return prod[24:17];
   endfunction

   function automatic logic [23:0] rainbow_color(input logic [16:0] hue);
      logic [19:0] h;
      logic [3:0]  sec;
      logic [15:0] f;
      logic [23:0] up_p;
      logic [24:0] dn_p;
      logic [7:0]  up;
      logic [7:0]  dn;
      logic [23:0] c;
      h = 20'(hue * 3'd6);
      sec = h[19:16];
      if (sec >= 4'd6) sec = sec - 4'd6;
      f = h[15:0];
      up_p = 24'(f * 8'd255);
      dn_p = 25'((17'd65536 - {1'b0, f}) * 8'd255);
      up = up_p[23:16];
      dn = dn_p[23:16];
      case (sec)
         4'd0: c = {8'd255, up, 8'd0};
         4'd1: c = {dn, 8'd255, 8'd0};
         4'd2: c = {8'd0, 8'd255, up};
         4'd3: c = {8'd0, dn, 8'd255};
         4'd4: c = {up, 8'd0, 8'd255};
         default: c = {8'd255, 8'd0, dn};
      endcase
      return c;
   endfunction

endpackage

/* design/rle_div.sv */
// Restoring divider, one quotient bit per cycle, for the LED effect renderer.
// Depends on rle_pkg.
module rle_div
   import rle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [DIVS_W-1:0] remainder
);

   logic [DIV_W-1:0]  dq_ff, dq_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;
   logic              qbit;

   always_comb begin
      dq_in = dq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, dq_ff[DIV_W-1]};
      qbit = trial >= {1'b0, dvs_ff};
      if (start) begin
         dq_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         dq_in = {dq_ff[DIV_W-2:0], qbit};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = dq_ff;
   assign remainder = rem_ff;

endmodule

/* design/rle_datapath.sv */
// Datapath of the LED effect renderer: time state, divider, color and output registers.
// Depends on rle_pkg and rle_div; driven by rle_ctrl commands.
module rle_datapath
   import rle_pkg::*;
#(
   parameter int NUM_LEDS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [6:0] NLEDS = 7'(NUM_LEDS);

   logic [9:0]  tick_ff;
   logic [15:0] phase_ff, el_ff;
   logic        fin_ff;
   logic [16:0] q_ff, q0_ff, o_ff;
   logic [6:0]  r0_ff, rem_ff;
   logic [7:0]  inten_ff, lit_ff;
   logic [23:0] solid_ff, col_ff;
   logic [5:0]  led_ff;
   logic        out_valid_ff;
   rsp_type     rsp_ff;

   logic [6:0]        start_c, count_c;
   logic [7:0]        end_sum;
   logic [15:0]       period_eff;
   logic [16:0]       el_sum;
   logic [15:0]       el_sat;
   logic              fin_set;
   logic              in_range;
   logic              div_start;
   logic [DIV_W-1:0]  dvd;
   logic [DIVS_W-1:0] dvs;
   logic              div_done;
   logic [DIV_W-1:0]  div_q;
   logic [DIVS_W-1:0] div_r;
   logic [31:0]       step_k;
   logic [17:0]       hue_sum;
   logic [16:0]       hue;
   logic [23:0]       raw;
   logic [7:0]        rsum;
   logic              last_c;

   always_comb begin
      start_c = ({1'b0, cfg.range_start} >= NLEDS) ? 7'd0 : {1'b0, cfg.range_start};
      end_sum = {1'b0, start_c} + {1'b0, cfg.range_count};
      count_c = (end_sum > {1'b0, NLEDS}) ? (NLEDS - start_c) : cfg.range_count;
      if (count_c == 7'd0) count_c = NLEDS;
      period_eff = (cfg.cycle_len == 16'd0) ? 16'd1 : cfg.cycle_len;
      el_sum = {1'b0, el_ff} + {7'd0, tick_ff};
      el_sat = el_sum[16] ? 16'hFFFF : el_sum[15:0];
      fin_set = (cfg.life_len != 16'd0) && (el_sat >= cfg.life_len);
      in_range = ({2'b0, led_ff} >= {1'b0, start_c})
               && ({2'b0, led_ff} < ({1'b0, start_c} + {1'b0, count_c}));
      last_c = {1'b0, led_ff} == (NLEDS - 7'd1);
   end

   always_comb begin
      dvs = period_eff;
      dvd = '0;
      unique case (cmd.div_sel)
         DIV_MOD: dvd = DIV_W'({1'b0, phase_ff} + {7'd0, tick_ff});
         DIV_RANGE: begin
            dvd = DIV_W'(32'd65536);
            dvs = {9'd0, count_c};
         end
         DIV_FRAME: begin
            case (cfg.effect_mode)
               MODE_BREATH:   dvd = DIV_W'(phase_ff * SINE_STEPS);
               MODE_FLOW:     dvd = DIV_W'(phase_ff * count_c);
               MODE_FLOW_REV: dvd = DIV_W'((period_eff - phase_ff) * count_c);
               MODE_RAINBOW:  dvd = {phase_ff, 16'd0};
               default:       dvd = '0;
            endcase
         end
         default: dvd = '0;
      endcase
   end

   assign div_start = cmd.div_start;

   rle_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      step_k = (32'(q_ff) * 32'd256) / SINE_STEPS;
      hue_sum = {2'b0, q_ff[15:0]} + {1'b0, o_ff};
      hue = (hue_sum > 18'd65536) ? 17'(hue_sum - 18'd65536) : hue_sum[16:0];
      raw = '0;
      if (!fin_ff && in_range) begin
         case (cfg.effect_mode) inside
            MODE_RAINBOW: raw = rainbow_color(hue);
            MODE_FLOW, MODE_FLOW_REV: raw = ({2'b0, led_ff} == lit_ff) ? solid_ff : 24'd0;
            MODE_STATIC, MODE_BREATH, MODE_BLINK: raw = solid_ff;
            default: raw = '0;
         endcase
      end
      rsum = {1'b0, rem_ff} + {1'b0, r0_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tick) tick_ff <= req_data.tick_ms;
      if (cmd.q_load) q_ff <= div_q[16:0];
      if (cmd.r_load) begin
         q0_ff <= div_q[16:0];
         r0_ff <= div_r[6:0];
      end
      if (cmd.prep) begin
         inten_ff <= (cfg.effect_mode == MODE_BREATH) ? breath_level(step_k[7:0]) : 8'd255;
         lit_ff <= {1'b0, start_c} + q_ff[7:0];
         o_ff <= '0;
         rem_ff <= '0;
      end
      if (cmd.solid1) solid_ff <= scale_color(cfg.base_color, inten_ff);
      if (cmd.solid2) begin
         if (cfg.effect_mode == MODE_BLINK && !(phase_ff < (period_eff >> 1)))
            solid_ff <= '0;
         else
            solid_ff <= scale_color(solid_ff, cfg.effect_brightness);
      end
      if (cmd.led_a) col_ff <= raw;
      if (cmd.led_b) col_ff <= scale_color(col_ff, cfg.effect_brightness);
      if (cmd.led_c) begin
         rsp_ff.pixel_num <= led_ff;
         rsp_ff.led_color <= scale_color(col_ff, cfg.master_level);
         rsp_ff.last <= last_c;
         if (in_range) begin
            if (rsum >= {1'b0, count_c}) begin
               rem_ff <= 7'(rsum - {1'b0, count_c});
               o_ff <= o_ff + q0_ff + 17'd1;
            end else begin
               rem_ff <= rsum[6:0];
               o_ff <= o_ff + q0_ff;
            end
         end
      end
      if (reset) begin
         phase_ff <= '0;
         el_ff <= '0;
         fin_ff <= 1'b0;
         led_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_tick && req_data.restart) begin
            phase_ff <= '0;
            el_ff <= '0;
            fin_ff <= 1'b0;
         end
         if (cmd.update && !fin_ff) begin
            el_ff <= el_sat;
            fin_ff <= fin_set;
         end
         if (cmd.phase_load) phase_ff <= div_r;
         if (cmd.prep) led_ff <= '0;
         if (cmd.led_c) led_ff <= last_c ? 6'd0 : led_ff + 6'd1;
         if (cmd.led_c) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   assign sts.div_done = div_done;
   assign sts.will_mod = !fin_ff && !fin_set;
   assign sts.is_rainbow = cfg.effect_mode == MODE_RAINBOW;
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign sts.led_last = last_c;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* design/rle_ctrl.sv */
// Sequencer of the LED effect renderer: tick update, divisions, frame walk.
// Depends on rle_pkg; commands rle_datapath.
module rle_ctrl
   import rle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.div_sel = DIV_FRAME;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_tick = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.will_mod) begin
               cmd.div_start = 1'b1;
               cmd.div_sel = DIV_MOD;
               state_in = S_MOD_WAIT;
            end else begin
               state_in = S_FDIV_GO;
            end
         end
         S_MOD_WAIT: begin
            if (sts.div_done) begin
               cmd.phase_load = 1'b1;
               state_in = S_FDIV_GO;
            end
         end
         S_FDIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_FDIV_WAIT;
         end
         S_FDIV_WAIT: begin
            if (sts.div_done) begin
               cmd.q_load = 1'b1;
               state_in = sts.is_rainbow ? S_RDIV_GO : S_PREP;
            end
         end
         S_RDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DIV_RANGE;
            state_in = S_RDIV_WAIT;
         end
         S_RDIV_WAIT: begin
            if (sts.div_done) begin
               cmd.r_load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SOLID1;
         end
         S_SOLID1: begin
            cmd.solid1 = 1'b1;
            state_in = S_SOLID2;
         end
         S_SOLID2: begin
            cmd.solid2 = 1'b1;
            state_in = S_LED_A;
         end
         S_LED_A: begin
            cmd.led_a = 1'b1;
            state_in = S_LED_B;
         end
         S_LED_B: begin
            cmd.led_b = sts.is_rainbow;
            state_in = S_LED_C;
         end
         S_LED_C: begin
            if (sts.out_free) begin
               cmd.led_c = 1'b1;
               state_in = sts.led_last ? S_IDLE : S_LED_A;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* design/rgb_led_effect_renderer.sv */
// Top level of the RGB LED effect renderer: register file, sequencer and datapath.
// Depends on rle_pkg, rle_ctrl, rle_datapath (and rle_div below it).
//
//   port group  direction  handshake               payload
//   req_        in         req_valid / req_ready   req_data (tick_ms, restart)
//   rsp_        out        rsp_valid / rsp_ready   rsp_data (pixel_num, led_color, last)
//   APB         in         psel, penable, pready   paddr, pwdata, prdata
//
// One tick transaction runs the 32-step serial divider for the phase modulo, the frame quotient
// and, in rainbow mode, the rainbow step; the phase modulo is skipped once the elapsed time has
// reached the lifetime. The divider sets most of the time a transaction takes.
// A new tick transaction is taken once the last LED color is in the output register.
// A stalled rsp_ready holds the walk at the next LED. Reset is synchronous and returns
// registers to their defaults and the phase, elapsed time and finished mark to zero.
module rgb_led_effect_renderer
   import rle_pkg::*;
#(
   parameter int NUM_LEDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   sts_type    sts;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MODE:     cfg_in.effect_mode = pwdata[2:0];
            REG_PERIOD:   cfg_in.cycle_len = pwdata[15:0];
            REG_DURATION: cfg_in.life_len = pwdata[15:0];
            REG_EFF_BRI:  cfg_in.effect_brightness = pwdata[7:0];
            REG_BASE:     cfg_in.base_color = pwdata[23:0];
            REG_START:    cfg_in.range_start = pwdata[5:0];
            REG_COUNT:    cfg_in.range_count = pwdata[6:0];
            REG_GLB_BRI:  cfg_in.master_level = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:     prdata = {29'd0, cfg_ff.effect_mode};
         REG_PERIOD:   prdata = {16'd0, cfg_ff.cycle_len};
         REG_DURATION: prdata = {16'd0, cfg_ff.life_len};
         REG_EFF_BRI:  prdata = {24'd0, cfg_ff.effect_brightness};
         REG_BASE:     prdata = {8'd0, cfg_ff.base_color};
         REG_START:    prdata = {26'd0, cfg_ff.range_start};
         REG_COUNT:    prdata = {25'd0, cfg_ff.range_count};
         REG_GLB_BRI:  prdata = {24'd0, cfg_ff.master_level};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode <= MODE_STATIC;
         cfg_ff.cycle_len <= 16'd1000;
         cfg_ff.life_len <= 16'd0;
         cfg_ff.effect_brightness <= 8'd255;
         cfg_ff.base_color <= 24'hFFFFFF;
         cfg_ff.range_start <= 6'd0;
         cfg_ff.range_count <= 7'd0;
         cfg_ff.master_level <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rle_datapath #(
      .NUM_LEDS (NUM_LEDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/rgb_led_effect_renderer_test.sv */
// Testbench for the RGB LED effect renderer: drives tick transactions and APB register
// writes, predicts every LED color per frame and checks the response stream in order.
// Depends on rle_pkg and the rgb_led_effect_renderer top level.
module rgb_led_effect_renderer_test;
   import rle_pkg::*;

   localparam int NLEDS = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cfg_type     shadow_cfg;
   logic [15:0] shadow_phase;
   logic [15:0] shadow_elapsed;
   logic        shadow_finished;
   rsp_type     pending_leds[$];
   int          error_count;
   int          idle_cycles;
   logic        quiet_mode;

   typedef struct {
      logic [9:0]  tick;
      logic        restart;
      logic [23:0] color0;
      logic        known;
   } tick_row_type;

   rgb_led_effect_renderer #(.NUM_LEDS(NLEDS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [23:0] dim(logic [23:0] c, logic [7:0] b);
      logic [31:0] r, g, bl;
      if (b == 8'd0) return 24'd0;
      if (b == 8'd255) return c;
      r = (32'(c[23:16]) * b) / 255;
      g = (32'(c[15:8]) * b) / 255;
      bl = (32'(c[7:0]) * b) / 255;
      return {r[7:0], g[7:0], bl[7:0]};
   endfunction

   function automatic logic [31:0] sine_q16(int j);
      logic [31:0] qs[0:64] = '{
         0, 1608, 3216, 4821, 6424, 8022, 9616, 11204, 12785, 14359, 15924, 17479,
         19024, 20557, 22078, 23586, 25080, 26558, 28020, 29466, 30893, 32303,
         33692, 35062, 36410, 37736, 39040, 40320, 41576, 42806, 44011, 45190,
         46341, 47464, 48559, 49624, 50660, 51665, 52639, 53581, 54491, 55368,
         56212, 57022, 57797, 58538, 59243, 59913, 60547, 61144, 61705, 62228,
         62714, 63162, 63572, 63943, 64277, 64571, 64827, 65043, 65220, 65358,
         65457, 65516, 65536};
      return qs[j];
   endfunction

   function automatic logic [7:0] breath_scale(logic [31:0] ph, logic [31:0] per);
      logic [31:0] stp, k, mag, num, lvl;
      stp = (ph * 256) / per;
      k = ((stp * 256) / 256) & 255;
      mag = k[6] ? sine_q16(64 - int'(k[5:0])) : sine_q16(int'(k[5:0]));
      num = k[7] ? 65536 - mag : 65536 + mag;
      lvl = (255 * num) / 131072;
      return lvl[7:0];
   endfunction

   function automatic logic [23:0] hue_color(logic [31:0] hue);
      logic [31:0] h, sec, f, up, dn;
      h = hue * 6;
      sec = (h >> 16) % 6;
      f = h & 32'hFFFF;
      up = (255 * f) >> 16;
      dn = (255 * (65536 - f)) >> 16;
      case (sec)
         0: return {8'd255, up[7:0], 8'd0};
         1: return {dn[7:0], 8'd255, 8'd0};
         2: return {8'd0, 8'd255, up[7:0]};
         3: return {8'd0, dn[7:0], 8'd255};
         4: return {up[7:0], 8'd0, 8'd255};
         default: return {8'd255, 8'd0, dn[7:0]};
      endcase
   endfunction

   task automatic render_frame(input logic [9:0] tick, input logic restart);
      logic [31:0] per, first, cnt, lit, hue, e;
      logic [23:0] solid, c;
      logic        one_lit;
      rsp_type     led;
      per = shadow_cfg.cycle_len == 0 ? 32'd1 : 32'(shadow_cfg.cycle_len);
      first = 32'(shadow_cfg.range_start);
      cnt = 32'(shadow_cfg.range_count);
      lit = 0;
      solid = '0;
      one_lit = 1'b0;
      if (restart) begin
         shadow_phase = '0;
         shadow_elapsed = '0;
         shadow_finished = 1'b0;
      end
      if (!shadow_finished) begin
         e = 32'(shadow_elapsed) + tick;
         shadow_elapsed = e > 32'hFFFF ? 16'hFFFF : e[15:0];
         if (shadow_cfg.life_len != 0 && shadow_elapsed >= shadow_cfg.life_len)
            shadow_finished = 1'b1;
         else
            shadow_phase = 16'((32'(shadow_phase) + tick) % per);
      end
      if (first >= NLEDS) first = 0;
      if (first + cnt > NLEDS) cnt = NLEDS - first;
      if (cnt == 0) cnt = NLEDS;
      case (shadow_cfg.effect_mode) inside
         MODE_STATIC: solid = dim(shadow_cfg.base_color, shadow_cfg.effect_brightness);
         MODE_BREATH: solid = dim(dim(shadow_cfg.base_color,
                                      breath_scale(32'(shadow_phase), per)),
                                  shadow_cfg.effect_brightness);
         MODE_FLOW, MODE_FLOW_REV: begin
            if (shadow_cfg.effect_mode == MODE_FLOW)
               lit = first + (32'(shadow_phase) * cnt) / per;
            else
               lit = first + ((per - shadow_phase) * cnt) / per;
            one_lit = 1'b1;
            solid = dim(shadow_cfg.base_color, shadow_cfg.effect_brightness);
         end
         MODE_BLINK: solid = (shadow_phase < per / 2) ?
                             dim(shadow_cfg.base_color, shadow_cfg.effect_brightness) : '0;
         default: solid = '0;
      endcase
      for (int i = 0; i < NLEDS; i++) begin
         c = '0;
         if (!shadow_finished && i >= first && i < first + cnt) begin
            if (shadow_cfg.effect_mode == MODE_RAINBOW) begin
               hue = (32'(shadow_phase) * 65536) / per + ((i - first) * 65536) / cnt;
               if (hue > 65536) hue -= 65536;
               c = dim(hue_color(hue), shadow_cfg.effect_brightness);
            end else if (one_lit) begin
               c = (i == lit) ? solid : '0;
            end else if (shadow_cfg.effect_mode <= MODE_BLINK) begin
               c = solid;
            end
         end
         led.pixel_num = i[5:0];
         led.led_color = dim(c, shadow_cfg.master_level);
         led.last = (i == NLEDS - 1);
         pending_leds.push_back(led);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_MODE:     shadow_cfg.effect_mode = value[2:0];
         REG_PERIOD:   shadow_cfg.cycle_len = value[15:0];
         REG_DURATION: shadow_cfg.life_len = value[15:0];
         REG_EFF_BRI:  shadow_cfg.effect_brightness = value[7:0];
         REG_BASE:     shadow_cfg.base_color = value[23:0];
         REG_START:    shadow_cfg.range_start = value[5:0];
         REG_COUNT:    shadow_cfg.range_count = value[6:0];
         default:      shadow_cfg.master_level = value[7:0];
      endcase
   endtask

   task automatic drain_frames();
      while (pending_leds.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic pause_random();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      if (quiet_mode) n = 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_tick(input logic [9:0] tick, input logic restart);
      @(posedge clock);
      req_valid <= 1'b1;
      req_data <= '{tick_ms: tick, restart: restart};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      render_frame(tick, restart);
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_leds.size() == 0) begin
               report_mismatch("unexpected led", 32'(rsp_data.pixel_num), 32'hFFFFFFFF);
            end else begin
               if (rsp_data.pixel_num != pending_leds[0].pixel_num)
                  report_mismatch("pixel_num", 32'(rsp_data.pixel_num),
                                  32'(pending_leds[0].pixel_num));
               if (rsp_data.led_color != pending_leds[0].led_color)
                  report_mismatch("led_color", 32'(rsp_data.led_color),
                                  32'(pending_leds[0].led_color));
               if (rsp_data.last != pending_leds[0].last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(pending_leds[0].last));
               void'(pending_leds.pop_front());
            end
         end
         if (quiet_mode)
            rsp_ready <= 1'b1;
         else if ($urandom_range(0, 49) == 0)
            rsp_ready <= 1'b0;
         else if (!rsp_ready)
            rsp_ready <= ($urandom_range(0, 5) == 0);
         else
            rsp_ready <= ($urandom_range(0, 7) != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   tick_row_type ticks[20] = '{
      '{10'd0,    1'b0, 24'hFFFFFF, 1'b1},
      '{10'd1023, 1'b0, 24'hFFFFFF, 1'b1},
      '{10'd1,    1'b1, 24'hFFFFFF, 1'b1},
      '{10'd512,  1'b0, 24'h0, 1'b0},
      '{10'd333,  1'b0, 24'h0, 1'b0},
      '{10'd0,    1'b1, 24'h0, 1'b0},
      '{10'd250,  1'b0, 24'h0, 1'b0},
      '{10'd250,  1'b0, 24'h0, 1'b0},
      '{10'd250,  1'b0, 24'h0, 1'b0},
      '{10'd250,  1'b0, 24'h0, 1'b0},
      '{10'd0,    1'b1, 24'h0, 1'b0},
      '{10'd100,  1'b0, 24'h0, 1'b0},
      '{10'd700,  1'b0, 24'h0, 1'b0},
      '{10'd999,  1'b0, 24'h0, 1'b0},
      '{10'd5,    1'b0, 24'h0, 1'b0},
      '{10'd0,    1'b1, 24'h0, 1'b0},
      '{10'd7,    1'b0, 24'h0, 1'b0},
      '{10'd1023, 1'b1, 24'h0, 1'b0},
      '{10'd682,  1'b0, 24'h0, 1'b0},
      '{10'd341,  1'b0, 24'h0, 1'b0}
   };

   initial begin
      logic [2:0]  mode;
      logic [15:0] per;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      error_count = 0;
      quiet_mode = 1'b0;
      shadow_cfg = '{effect_mode: MODE_STATIC, cycle_len: 16'd1000, life_len: 16'd0,
                     effect_brightness: 8'd255, base_color: 24'hFFFFFF,
                     range_start: 6'd0, range_count: 7'd0, master_level: 8'd255};
      shadow_phase = '0;
      shadow_elapsed = '0;
      shadow_finished = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: full white on all LEDs
      for (int r = 0; r < 3; r++) begin
         send_tick(ticks[r].tick, ticks[r].restart);
         if (ticks[r].known && pending_leds[pending_leds.size() - 1].led_color !=
             ticks[r].color0)
            report_mismatch("table color",
                            32'(pending_leds[pending_leds.size() - 1].led_color),
                            32'(ticks[r].color0));
         pause_random();
      end
      for (int r = 3; r < 20; r++) begin
         drain_frames();
         case (r)
            3:  write_reg(REG_MODE, 32'(MODE_BREATH));
            5:  begin
               write_reg(REG_MODE, 32'(MODE_FLOW_REV));
               write_reg(REG_START, 32'd62);
               write_reg(REG_COUNT, 32'd64);
            end
            7:  write_reg(REG_MODE, 32'(MODE_FLOW));
            9:  begin
               write_reg(REG_MODE, 32'(MODE_BLINK));
               write_reg(REG_START, 32'd4);
               write_reg(REG_COUNT, 32'd20);
            end
            10: begin
               write_reg(REG_MODE, 32'(MODE_RAINBOW));
               write_reg(REG_PERIOD, 32'd0);
            end
            12: begin
               write_reg(REG_PERIOD, 32'd65535);
               write_reg(REG_EFF_BRI, 32'd0);
            end
            13: begin
               write_reg(REG_MODE, 32'd7);
               write_reg(REG_EFF_BRI, 32'd128);
            end
            14: begin
               write_reg(REG_MODE, 32'(MODE_STATIC));
               write_reg(REG_DURATION, 32'd10);
               write_reg(REG_BASE, 32'h123456);
               write_reg(REG_GLB_BRI, 32'd0);
            end
            16: begin
               write_reg(REG_DURATION, 32'd65535);
               write_reg(REG_GLB_BRI, 32'd1);
               write_reg(REG_BASE, 32'h000000);
            end
            17: write_reg(REG_MODE, 32'd6);
            default: ;
         endcase
         send_tick(ticks[r].tick, ticks[r].restart);
      end

      for (int phase_idx = 0; phase_idx < 11; phase_idx++) begin
         drain_frames();
         mode = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 4) != 0 && mode > 5) mode = 3'($urandom_range(0, 5));
         per = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
               16'($urandom_range(1, 2000));
         write_reg(REG_MODE, 32'(mode));
         write_reg(REG_PERIOD, 32'(per));
         write_reg(REG_DURATION, ($urandom_range(0, 2) == 0) ?
                   $urandom_range(1, 20000) : 0);
         write_reg(REG_EFF_BRI, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
         write_reg(REG_BASE, $urandom());
         write_reg(REG_START, $urandom_range(0, 63) < 48 ? $urandom_range(0, 15) :
                   $urandom_range(0, 63));
         write_reg(REG_COUNT, $urandom_range(0, 64));
         write_reg(REG_GLB_BRI, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
         quiet_mode = (phase_idx == 5);
         for (int n = 0; n < 30; n++) begin
            if (n == 15) drain_frames();
            send_tick(($urandom_range(0, 4) == 0) ? 10'($urandom()) :
                      10'($urandom_range(0, 40)), $urandom_range(0, 19) == 0);
            pause_random();
         end
      end

      quiet_mode = 1'b0;
      drain_frames();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
design/rle_pkg.sv
design/rle_div.sv
design/rle_datapath.sv
design/rle_ctrl.sv
design/rgb_led_effect_renderer.sv
bench/rgb_led_effect_renderer_test.sv
